FILE: src/svpt_pkg.sv
package svpt_pkg;

  localparam int unsigned PPN_W   = 44;
  localparam int unsigned PA_W    = 56;
  localparam int unsigned VA_W    = 39;
  localparam int unsigned VPN_W   = 9;
  localparam int unsigned OFF_W   = 12;
  localparam int unsigned PTE_W   = 64;
  localparam int unsigned WADDR_W = 12;

  localparam int unsigned PTE_V_BIT   = 0;
  localparam int unsigned PTE_U_BIT   = 4;
  localparam int unsigned PTE_PPN_LSB = 10;

  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_OUT_OF_RANGE = 2'd1;
  localparam logic [1:0] STATUS_NOT_MAPPED   = 2'd2;
  localparam logic [1:0] STATUS_NOT_USER     = 2'd3;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_XLATE = 1'b1;

  localparam logic CFG_ROOT_PPN     = 1'b0;
  localparam logic CFG_REQUIRE_USER = 1'b1;

  localparam logic [1:0] LEVEL_ROOT = 2'd2;

  typedef struct packed {
    logic             valid;
    logic             user;
    logic [PPN_W-1:0] ppn;
  } pte_info_t;

endpackage

FILE: src/svpt_ram.sv
module svpt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/svpt_walk_unit.sv
module svpt_walk_unit
  import svpt_pkg::*;
#(
  parameter int unsigned ADDR_W = 12
) (
  input  logic [PPN_W-1:0]  ppn_i,
  input  logic [VA_W-1:0]   va_i,
  input  logic [1:0]        level_i,
  input  logic [PTE_W-1:0]  entry_i,
  output logic [ADDR_W-1:0] addr_o,
  output pte_info_t         info_o
);

  logic [VPN_W-1:0]       vpn_idx;
  logic [PPN_W+VPN_W-1:0] table_word;

  always_comb begin
    unique case (level_i)
      2'd2:    vpn_idx = va_i[OFF_W+2*VPN_W +: VPN_W];
      2'd1:    vpn_idx = va_i[OFF_W+VPN_W +: VPN_W];
      2'd0:    vpn_idx = va_i[OFF_W +: VPN_W];
      default: vpn_idx = '0;
    endcase
  end

  // The store size is a power of two, so the wrap is a plain truncation.
  assign table_word = {ppn_i, vpn_idx};
  assign addr_o     = table_word[ADDR_W-1:0];

  assign info_o.valid = entry_i[PTE_V_BIT];
  assign info_o.user  = entry_i[PTE_U_BIT];
  assign info_o.ppn   = entry_i[PTE_PPN_LSB +: PPN_W];

endmodule

FILE: src/sv39_page_table_walker.sv
// Sv39 page table walker over a local store of STORE_WORDS 64-bit page table
// words (STORE_WORDS must be a power of two). After reset the store is cleared
// one word per cycle; in_ready_o stays low until that is done, while
// configuration writes are taken at any time. A write item or an out-of-range
// address gives its result in the cycle after acceptance. A translation reads
// one entry per level through the single store port with a registered read,
// and its result is registered once the leaf or a failing entry is checked.
// One item is in flight at a time: the next item is accepted once the result
// has been taken. Addresses that fail return status with both addresses zero.
module sv39_page_table_walker
  import svpt_pkg::*;
#(
  parameter int unsigned STORE_WORDS   = 4096,
  parameter int unsigned VA_LIMIT_BITS = 38
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [PPN_W-1:0]   cfg_data_i,

  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [WADDR_W-1:0] word_addr_i,
  input  logic [PTE_W-1:0]   pte_data_i,
  input  logic [63:0]        virt_addr_i,

  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PA_W-1:0]    phys_page_addr_o,
  output logic [PA_W-1:0]    phys_byte_addr_o,
  output logic [1:0]         status_o
);

  localparam int unsigned ADDR_W = $clog2(STORE_WORDS);
  localparam int unsigned WEXT_W = (ADDR_W > WADDR_W) ? ADDR_W : WADDR_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [1:0]        lvl_q, lvl_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [PPN_W-1:0]  root_ppn_q;
  logic              require_user_q;
  logic [VA_W-1:0]   va_q, va_d;
  logic [PA_W-1:0]   page_q, page_d;
  logic [PA_W-1:0]   byte_q, byte_d;
  logic [1:0]        status_q, status_d;

  logic              in_accept;
  logic              out_of_range;
  logic [WEXT_W-1:0] wr_word;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [PTE_W-1:0]  ram_wdata;
  logic [PTE_W-1:0]  ram_rdata;

  logic [PPN_W-1:0]  unit_ppn;
  logic [VA_W-1:0]   unit_va;
  logic [1:0]        unit_lvl;
  logic [ADDR_W-1:0] unit_addr;
  pte_info_t         entry_info;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE) && !out_valid_q;
  assign in_accept   = in_valid_i && in_ready_o;

  assign out_of_range = |(virt_addr_i >> VA_LIMIT_BITS);
  assign wr_word      = WEXT_W'(word_addr_i);

  // In idle the unit forms the root table address from the incoming item;
  // during the walk it forms the next-level address from the entry just read.
  always_comb begin
    if (state_q == ST_IDLE) begin
      unit_ppn = root_ppn_q;
      unit_va  = virt_addr_i[VA_W-1:0];
      unit_lvl = LEVEL_ROOT;
    end else begin
      unit_ppn = entry_info.ppn;
      unit_va  = va_q;
      unit_lvl = 2'(lvl_q - 2'd1);
    end
  end

  svpt_walk_unit #(
    .ADDR_W(ADDR_W)
  ) u_walk_unit (
    .ppn_i  (unit_ppn),
    .va_i   (unit_va),
    .level_i(unit_lvl),
    .entry_i(ram_rdata),
    .addr_o (unit_addr),
    .info_o (entry_info)
  );

  svpt_ram #(
    .WIDTH(PTE_W),
    .DEPTH(STORE_WORDS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    lvl_d       = lvl_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    va_d        = va_q;
    page_d      = page_q;
    byte_d      = byte_q;
    status_d    = status_q;
    ram_we      = 1'b0;
    ram_addr    = unit_addr;
    ram_wdata   = pte_data_i;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == ADDR_W'(STORE_WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          page_d = '0;
          byte_d = '0;
          va_d   = virt_addr_i[VA_W-1:0];
          if (req_type_i == REQ_WRITE) begin
            ram_we      = 1'b1;
            ram_addr    = wr_word[ADDR_W-1:0];
            status_d    = STATUS_OK;
            out_valid_d = 1'b1;
          end else if (out_of_range) begin
            status_d    = STATUS_OUT_OF_RANGE;
            out_valid_d = 1'b1;
          end else begin
            lvl_d   = LEVEL_ROOT;
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (!entry_info.valid) begin
          status_d    = STATUS_NOT_MAPPED;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else if (lvl_q != 2'd0) begin
          lvl_d = 2'(lvl_q - 2'd1);
        end else if (require_user_q && !entry_info.user) begin
          status_d    = STATUS_NOT_USER;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          // The page address has zero low bits, so adding the offset cannot carry.
          page_d      = {entry_info.ppn, {OFF_W{1'b0}}};
          byte_d      = {entry_info.ppn, va_q[OFF_W-1:0]};
          status_d    = STATUS_OK;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      lvl_q          <= '0;
      clr_cnt_q      <= '0;
      out_valid_q    <= 1'b0;
      root_ppn_q     <= '0;
      require_user_q <= 1'b1;
    end else begin
      state_q     <= state_d;
      lvl_q       <= lvl_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_ROOT_PPN:     root_ppn_q     <= cfg_data_i;
          CFG_REQUIRE_USER: require_user_q <= cfg_data_i[0];
          default:          root_ppn_q     <= root_ppn_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    va_q     <= va_d;
    page_q   <= page_d;
    byte_q   <= byte_d;
    status_q <= status_d;
  end

  assign out_valid_o      = out_valid_q;
  assign phys_page_addr_o = page_q;
  assign phys_byte_addr_o = byte_q;
  assign status_o         = status_q;

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STATUS_OK) |->
      (phys_page_addr_o == '0) && (phys_byte_addr_o == '0))
    else $error("failed result carries a nonzero address");

  a_leaf_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) && (lvl_q == 2'd0) |=> out_valid_o && (state_q == ST_IDLE))
    else $error("leaf read did not produce a result");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item accepted before the first result was taken");

  a_byte_in_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> phys_byte_addr_o[PA_W-1:OFF_W] == phys_page_addr_o[PA_W-1:OFF_W])
    else $error("byte address left its page");

  a_no_result_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !out_valid_o && !in_ready_o)
    else $error("activity during the clearing pass");

endmodule
